### design/integer_to_roman_numeral_assert.svh
// assertion macros used by the converter back end
// all checks run on the rising edge of clk and are off while arst_n is low
`ifndef INTEGER_TO_ROMAN_NUMERAL_ASSERT_SVH
`define INTEGER_TO_ROMAN_NUMERAL_ASSERT_SVH

`ifndef SYNTHESIS

// property holds at the same edge
`define ITR_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("itr assertion failed");

// consequent holds at the edge after the antecedent
`define ITR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("itr assertion failed");

`else

`define ITR_ASSERT(lbl, prop)
`define ITR_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### design/itr_pkg.sv
package itr_pkg;

	// field widths
	localparam int VALUE_W = 12;
	localparam int SYM_W = 7;

	// largest number with a numeral
	localparam logic [VALUE_W-1:0] MAX_VALUE = VALUE_W'(3999);

	// queue between the front and the back
	localparam int QUEUE_DEPTH_DEF = 2;

	// greedy table, largest weight first
	localparam int TABLE_LEN = 13;
	localparam int IDX_W = $clog2(TABLE_LEN);

	// ascii codes of the numeral characters
	localparam logic [SYM_W-1:0] SYM_NONE = 7'h00;
	localparam logic [SYM_W-1:0] SYM_I = 7'h49;
	localparam logic [SYM_W-1:0] SYM_V = 7'h56;
	localparam logic [SYM_W-1:0] SYM_X = 7'h58;
	localparam logic [SYM_W-1:0] SYM_L = 7'h4c;
	localparam logic [SYM_W-1:0] SYM_C = 7'h43;
	localparam logic [SYM_W-1:0] SYM_D = 7'h44;
	localparam logic [SYM_W-1:0] SYM_M = 7'h4d;

	localparam logic [VALUE_W-1:0] RN_WEIGHT [TABLE_LEN] = '{
		12'd1000, 12'd900, 12'd500, 12'd400, 12'd100, 12'd90, 12'd50,
		12'd40, 12'd10, 12'd9, 12'd5, 12'd4, 12'd1
	};

	localparam logic [SYM_W-1:0] RN_FIRST [TABLE_LEN] = '{
		SYM_M, SYM_C, SYM_D, SYM_C, SYM_C, SYM_X, SYM_L,
		SYM_X, SYM_X, SYM_I, SYM_V, SYM_I, SYM_I
	};

	// second character of a subtractive pair, none for a single character
	localparam logic [SYM_W-1:0] RN_SECOND [TABLE_LEN] = '{
		SYM_NONE, SYM_M, SYM_NONE, SYM_D, SYM_NONE, SYM_C, SYM_NONE,
		SYM_L, SYM_NONE, SYM_X, SYM_NONE, SYM_V, SYM_NONE
	};

	// classified number on its way to the back
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               err;
	} itr_item_t;

	// one result word
	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             last;
		logic             err;
	} itr_word_t;

	// handshake between a producer and the queue
	typedef struct packed {
		logic       valid;
		itr_item_t  item;
	} itr_q_in_t;

endpackage

### design/itr_front.sv
module itr_front import itr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [VALUE_W-1:0] value,
	output itr_q_in_t          q_wr,
	input  logic               q_full
);

	logic      valid_s1;
	itr_item_t item_s1;
	logic      accept;
	logic      move;

	// hand the stage on whenever the queue has room
	assign move = valid_s1 && !q_full;
	assign full = valid_s1 && q_full;
	assign accept = push && !full;

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (move) begin
			valid_s1 <= 1'b0;
		end
	end

	// classify: zero and values past the top of the range are errors
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.value <= value;
			item_s1.err <= (value == '0) || (value > MAX_VALUE);
		end
	end

	assign q_wr.valid = move;
	assign q_wr.item = item_s1;

endmodule

### design/itr_queue.sv
module itr_queue import itr_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  itr_q_in_t wr,
	output logic      full,
	input  logic      rd,
	output logic      empty,
	output itr_item_t rd_item
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	itr_item_t        mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full = (count_q == CNT_FULL);
	assign empty = (count_q == '0);
	assign do_wr = wr.valid && !full;
	assign do_rd = rd && !empty;
	assign rd_item = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr.item;
		end
	end

endmodule

### design/itr_back.sv
`include "integer_to_roman_numeral_assert.svh"

module itr_back import itr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  itr_item_t        q_item,
	output logic             q_pop,
	output logic             empty,
	input  logic             pop,
	output logic [SYM_W-1:0] symbol,
	output logic             last,
	output logic             error
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_PEND = 3'b100
	} itr_state_t;

	itr_state_t         state_q, state_d;
	logic [VALUE_W-1:0] rest_q, rest_d;
	logic               err_q, err_d;
	logic [SYM_W-1:0]   pend_q, pend_d;
	logic               out_valid_q;
	itr_word_t          out_q;
	itr_word_t          word_d;
	logic               emit;
	logic               emit_ok;
	logic [IDX_W-1:0]   sel;
	logic [VALUE_W-1:0] rest_sub;

	assign emit_ok = !out_valid_q || pop;

	// largest table weight that still fits in the rest
	always_comb begin
		sel = IDX_W'(TABLE_LEN - 1);
		for (int i = TABLE_LEN - 1; i >= 0; i--) begin
			if (rest_q >= RN_WEIGHT[i]) begin
				sel = IDX_W'(i);
			end
		end
	end

	assign rest_sub = rest_q - RN_WEIGHT[sel];

	// sequencer: load, then one character per cycle when free
	always_comb begin
		state_d = state_q;
		rest_d = rest_q;
		err_d = err_q;
		pend_d = pend_q;
		q_pop = 1'b0;
		emit = 1'b0;
		word_d = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					q_pop = 1'b1;
					rest_d = q_item.value;
					err_d = q_item.err;
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (emit_ok) begin
					emit = 1'b1;
					if (err_q) begin
						word_d.symbol = SYM_NONE;
						word_d.last = 1'b1;
						word_d.err = 1'b1;
						state_d = ST_IDLE;
					end else begin
						word_d.symbol = RN_FIRST[sel];
						rest_d = rest_sub;
						if (RN_SECOND[sel] != SYM_NONE) begin
							pend_d = RN_SECOND[sel];
							state_d = ST_PEND;
						end else begin
							word_d.last = (rest_sub == '0);
							state_d = (rest_sub == '0) ? ST_IDLE : ST_RUN;
						end
					end
				end
			end
			ST_PEND: begin
				if (emit_ok) begin
					emit = 1'b1;
					word_d.symbol = pend_q;
					word_d.last = (rest_q == '0);
					state_d = (rest_q == '0) ? ST_IDLE : ST_RUN;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working number and output word
	always_ff @(posedge clk) begin
		rest_q <= rest_d;
		err_q <= err_d;
		pend_q <= pend_d;
		if (emit) begin
			out_q <= word_d;
		end
	end

	assign empty = !out_valid_q;
	assign symbol = out_q.symbol;
	assign last = out_q.last;
	assign error = out_q.err;

	// an error word is alone and carries no character
	`ITR_ASSERT(a_err_word, (out_valid_q && out_q.err) |-> (out_q.last && (out_q.symbol == SYM_NONE)))
	// a second character is never pending straight after a load
	`ITR_ASSERT_NEXT(a_pend_from_run, (state_q == ST_IDLE), (state_q != ST_PEND))
	// the back only takes from a queue that holds something
	`ITR_ASSERT(a_pop_nonempty, q_pop |-> !q_empty)

endmodule

### design/integer_to_roman_numeral.sv
// Integer to Roman numeral converter. Push a 12-bit number; the block answers
// with its numeral one character per word (ASCII I, V, X, L, C, D, M), largest
// values first, with the subtractive pairs CM, CD, XC, XL, IX and IV, and with
// last set on the final character. A value of 0 or above 3999 gives a single
// word with error and last set and symbol 0. The back end loads a number from
// the internal queue in its idle state and then gives one character per cycle
// while its output word is free or being popped (up to 15 characters, for
// 3888). The front end and a QUEUE_DEPTH-entry queue keep taking numbers while
// the back end works, so push is stalled only when they fill.
module integer_to_roman_numeral import itr_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [VALUE_W-1:0] value,
	output logic               empty,
	input  logic               pop,
	output logic [SYM_W-1:0]   symbol,
	output logic               last,
	output logic               error
);

	itr_q_in_t q_wr;
	logic      q_full;
	logic      q_empty;
	logic      q_pop;
	itr_item_t q_item;

	// accept and classify
	itr_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.value  (value),
		.q_wr   (q_wr),
		.q_full (q_full)
	);

	// decoupling queue
	itr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.full    (q_full),
		.rd      (q_pop),
		.empty   (q_empty),
		.rd_item (q_item)
	);

	// character sequencer
	itr_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_item  (q_item),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.symbol  (symbol),
		.last    (last),
		.error   (error)
	);

endmodule

### test/tb_top.sv
module tb_top;
	import itr_pkg::*;

	// idling phases of the run
	typedef enum int {
		PH_STEADY,
		PH_SEND_IDLE,
		PH_RECV_STALL,
		PH_BOTH_IDLE,
		PH_HOLD_OFF
	} phase_t;

	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 40;
	localparam int STEPS = 13;

	// greedy steps of the numeral, largest first
	localparam int unsigned STEP_WEIGHT [STEPS] = '{
		1000, 900, 500, 400, 100, 90, 50, 40, 10, 9, 5, 4, 1
	};
	localparam string STEP_TEXT [STEPS] = '{
		"M", "CM", "D", "CD", "C", "XC", "L", "XL", "X", "IX", "V", "IV", "I"
	};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               push = 1'b0;
	logic               full;
	logic [VALUE_W-1:0] value = '0;
	logic               empty;
	logic               pop = 1'b0;
	logic [SYM_W-1:0]   symbol;
	logic               last;
	logic               error;

	phase_t             phase = PH_STEADY;
	bit                 hold_off = 1'b0;
	int                 fail_count = 0;
	logic [VALUE_W-1:0] pending_values [$];
	itr_word_t          numeral_words [$];
	itr_word_t          want;

	integer_to_roman_numeral DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.value  (value),
		.empty  (empty),
		.pop    (pop),
		.symbol (symbol),
		.last   (last),
		.error  (error)
	);

	// clock
	initial begin
		forever #4 clk = ~clk;
	end

	// run limit
	initial begin
		#2000000;
		$display("tb_top NOT OK");
		$finish;
	end

	// expected words of one number, numeral characters largest first
	function automatic void predict_numeral(input logic [VALUE_W-1:0] num);
		int unsigned rest;
		itr_word_t   w;
		rest = num;
		if (rest == 0 || rest > MAX_VALUE) begin
			w.symbol = SYM_NONE;
			w.last = 1'b1;
			w.err = 1'b1;
			numeral_words.push_back(w);
		end else begin
			for (int i = 0; i < STEPS; i++) begin
				while (rest >= STEP_WEIGHT[i]) begin
					rest -= STEP_WEIGHT[i];
					for (int j = 0; j < STEP_TEXT[i].len(); j++) begin
						w.symbol = SYM_W'(STEP_TEXT[i][j]);
						w.last = (rest == 0) && (j == STEP_TEXT[i].len() - 1);
						w.err = 1'b0;
						numeral_words.push_back(w);
					end
				end
			end
		end
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $time, what);
		fail_count++;
	endtask

	// random number, mostly legal, with zero and out of range mixed in
	function automatic logic [VALUE_W-1:0] pick_value();
		int sel;
		sel = $urandom_range(99);
		if (sel < 7)
			return '0;
		else if (sel < 15)
			return VALUE_W'($urandom_range(4095, 4000));
		else if (sel < 30)
			return VALUE_W'($urandom_range(49, 1));
		else if (sel < 40)
			return VALUE_W'($urandom_range(3899, 3700));
		else
			return VALUE_W'($urandom_range(3999, 1));
	endfunction

	function automatic bit sender_idles();
		case (phase)
			PH_SEND_IDLE: return $urandom_range(99) < 59;
			PH_BOTH_IDLE: return $urandom_range(99) < 6;
			default: return 1'b0;
		endcase
	endfunction

	function automatic bit receiver_stalls();
		case (phase)
			PH_RECV_STALL: return $urandom_range(99) < 59;
			PH_BOTH_IDLE: return $urandom_range(99) < 6;
			default: return 1'b0;
		endcase
	endfunction

	// driver: offer the next number at the falling edge, noise on value otherwise
	always @(negedge clk) begin
		if (arst_n && pending_values.size() > 0 && !sender_idles()) begin
			push <= 1'b1;
			value <= pending_values[0];
		end else begin
			push <= 1'b0;
			value <= VALUE_W'($urandom);
		end
	end

	// receiver: pop unless stalled or held off
	always @(negedge clk) begin
		pop <= arst_n && !hold_off && !receiver_stalls();
	end

	// monitor: predict on accepted numbers, check accepted words
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				predict_numeral(value);
				void'(pending_values.pop_front());
			end
			if (pop && !empty) begin
				if (numeral_words.size() == 0) begin
					report_mismatch($sformatf("word %h with nothing expected", symbol));
				end else begin
					want = numeral_words.pop_front();
					if (symbol !== want.symbol)
						report_mismatch($sformatf("symbol expected %h got %h",
							want.symbol, symbol));
					if (last !== want.last)
						report_mismatch($sformatf("last expected %b got %b",
							want.last, last));
					if (error !== want.err)
						report_mismatch($sformatf("error expected %b got %b",
							want.err, error));
				end
			end
		end
	end

	// long receiver hold-off so the block fills and stalls push
	initial begin
		wait (phase == PH_HOLD_OFF);
		hold_off = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off = 1'b0;
	end

	task automatic wait_drained();
		while (pending_values.size() > 0 || numeral_words.size() > 0)
			@(posedge clk);
	endtask

	task automatic run_phase(input phase_t ph, input int count);
		phase = ph;
		for (int i = 0; i < count; i++)
			pending_values.push_back(pick_value());
		wait_drained();
	endtask

	// stimulus
	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: range edges, every step weight but 10 and 100, longest numeral, bit patterns
		pending_values = '{
			12'd0, 12'd4095, 12'd4000, 12'd3999, 12'd1, 12'd3888, 12'd4, 12'd9,
			12'd40, 12'd90, 12'd400, 12'd900, 12'd5, 12'd50, 12'd500, 12'd1000,
			12'd2, 12'd3, 12'd1994, 12'd444, 12'd3000, 12'd14, 12'hAAA, 12'h555
		};
		wait_drained();

		run_phase(PH_STEADY, 60);
		run_phase(PH_SEND_IDLE, 60);
		run_phase(PH_RECV_STALL, 60);
		run_phase(PH_BOTH_IDLE, 60);
		run_phase(PH_HOLD_OFF, 40);
		run_phase(PH_STEADY, 50);

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

### filelist.f
+incdir+design
design/itr_pkg.sv
design/itr_front.sv
design/itr_queue.sv
design/itr_back.sv
design/integer_to_roman_numeral.sv
test/tb_top.sv
